// ===== rtl/cpt_pkg.sv =====
package cpt_pkg;

    localparam int ENTRY_W   = 21;
    localparam int COEF_W    = 32;
    localparam int ROW_W     = 3 * ENTRY_W;
    localparam int TI_W      = 32;
    localparam int ADJ_W     = 43;
    localparam int DET_W     = 64;
    localparam int NUM_W     = ADJ_W + 31;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;
    localparam int LAST_ENT  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0 = 2'd0,
        REG_ROW1 = 2'd1,
        REG_ROW2 = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        INV_IDLE,
        INV_ADJ_A,
        INV_ADJ_B,
        INV_DET,
        INV_CHECK,
        INV_LOAD,
        INV_DIV,
        INV_STORE
    } inv_state_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_xx;
        logic signed [COEF_W-1:0] coef_yy;
        logic signed [COEF_W-1:0] coef_xy;
        logic signed [COEF_W-1:0] coef_x;
        logic signed [COEF_W-1:0] coef_y;
        logic signed [COEF_W-1:0] coef_const;
    } in_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] out_xx;
        logic signed [COEF_W-1:0] out_yy;
        logic signed [COEF_W-1:0] out_xy;
        logic signed [COEF_W-1:0] out_x;
        logic signed [COEF_W-1:0] out_y;
        logic signed [COEF_W-1:0] out_const;
        logic                     invertible;
    } out_t;

    typedef logic [2:0][ROW_W-1:0] rows_t;
    typedef logic [8:0][TI_W-1:0]  ti_bank_t;

    function automatic logic [1:0] mod3(input logic [2:0] v);
        logic [1:0] r;
        case (v)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd0;
            3'd4:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] ent_row(input logic [3:0] e);
        logic [1:0] r;
        case (e)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] ent_col(input logic [3:0] e);
        logic [1:0] r;
        case (e)
            4'd0, 4'd3, 4'd6: r = 2'd0;
            4'd1, 4'd4, 4'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic int out_row(input int o);
        int r;
        case (o)
            0:       r = 1;
            1:       r = 2;
            2:       r = 1;
            default: r = 0;
        endcase
        return r;
    endfunction

    function automatic int out_col(input int o);
        int r;
        case (o)
            0:       r = 1;
            1:       r = 2;
            2:       r = 2;
            3:       r = 1;
            4:       r = 2;
            default: r = 0;
        endcase
        return r;
    endfunction

    function automatic int out_shift(input int o);
        int r;
        case (o)
            2, 3, 4: r = 15;
            default: r = 16;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/cpt_inverse.sv =====
module cpt_inverse
    import cpt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     go,
    input  rows_t    rows,
    output logic     busy,
    output logic     inv_ok,
    output ti_bank_t ti_bank
);

    inv_state_t state_reg, state_next;
    logic [3:0] ent_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic signed [ADJ_W-1:0] acc_reg;
    logic signed [ADJ_W-1:0] adj_mem [9];
    logic signed [DET_W-1:0] det_reg;
    logic [DET_W-1:0] dmag_reg;
    logic det_neg_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DET_W-1:0] rem_reg;
    logic [32:0] q_reg;
    logic sat_reg;
    logic neg_reg;
    logic ok_reg;
    ti_bank_t ti_reg;

    logic signed [ENTRY_W-1:0] t_m [3][3];
    logic [1:0] ei, ej;
    logic signed [ENTRY_W-1:0] ma, mb;
    logic signed [2*ENTRY_W-1:0] adj_prod;
    logic [3:0] rd_idx;
    logic signed [ADJ_W-1:0] adj_rd;
    logic signed [DET_W-1:0] det_prod;
    logic [DET_W:0] rem_sh;
    logic [DET_W:0] rem_diff;
    logic qbit;
    logic [33:0] m_round;
    logic [32:0] m_mag;
    logic big;
    logic [TI_W-1:0] ti_val;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                t_m[r][k] = rows[r][ENTRY_W*k +: ENTRY_W];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            INV_IDLE:
            begin
                if (go)
                begin
                    state_next = INV_ADJ_A;
                end
            end
            INV_ADJ_A: state_next = INV_ADJ_B;
            INV_ADJ_B: state_next = (ent_reg == 4'(LAST_ENT)) ? INV_DET : INV_ADJ_A;
            INV_DET:   state_next = (ent_reg == 4'd2) ? INV_CHECK : INV_DET;
            INV_CHECK: state_next = (det_reg == '0) ? INV_IDLE : INV_LOAD;
            INV_LOAD:  state_next = INV_DIV;
            INV_DIV:   state_next = (cnt_reg == CNT_W'(DIV_STEPS - 1)) ? INV_STORE : INV_DIV;
            INV_STORE: state_next = (ent_reg == 4'(LAST_ENT)) ? INV_IDLE : INV_LOAD;
            default:   state_next = INV_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != INV_IDLE);
        ei = ent_row(ent_reg);
        ej = ent_col(ent_reg);
        if (state_reg == INV_ADJ_A)
        begin
            ma = t_m[mod3({1'b0, ej} + 3'd1)][mod3({1'b0, ei} + 3'd1)];
            mb = t_m[mod3({1'b0, ej} + 3'd2)][mod3({1'b0, ei} + 3'd2)];
        end
        else
        begin
            ma = t_m[mod3({1'b0, ej} + 3'd1)][mod3({1'b0, ei} + 3'd2)];
            mb = t_m[mod3({1'b0, ej} + 3'd2)][mod3({1'b0, ei} + 3'd1)];
        end
        if (state_reg == INV_DET)
        begin
            rd_idx = {1'b0, ent_reg[1:0], 1'b0} + {2'b0, ent_reg[1:0]};
        end
        else
        begin
            rd_idx = ent_reg;
        end
    end

    assign adj_prod = ma * mb;
    assign adj_rd   = adj_mem[rd_idx];
    assign det_prod = t_m[0][ent_reg[1:0]] * adj_rd;

    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign qbit     = (rem_sh >= {1'b0, dmag_reg});
    assign rem_diff = rem_sh - {1'b0, dmag_reg};

    assign big     = sat_reg | q_reg[32];
    assign m_round = {1'b0, q_reg} + 34'd1;
    assign m_mag   = m_round[33:1];

    always_comb
    begin
        if (neg_reg)
        begin
            ti_val = big ? 32'h8000_0000 : (32'd0 - m_mag[31:0]);
        end
        else if (big || m_mag > 33'h0_7FFF_FFFF)
        begin
            ti_val = 32'h7FFF_FFFF;
        end
        else
        begin
            ti_val = m_mag[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= INV_IDLE;
            ent_reg   <= '0;
            cnt_reg   <= '0;
            ok_reg    <= 1'b1;
            ti_reg    <= {32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h0001_0000,
                          32'd0, 32'd0, 32'd0, 32'h0001_0000};
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                INV_IDLE:
                begin
                    ent_reg <= '0;
                end
                INV_ADJ_B, INV_DET:
                begin
                    if (state_next != state_reg && state_next != INV_ADJ_A)
                    begin
                        ent_reg <= '0;
                    end
                    else if (state_reg == INV_DET || state_next == INV_ADJ_A)
                    begin
                        ent_reg <= ent_reg + 4'd1;
                    end
                end
                INV_CHECK:
                begin
                    ent_reg <= '0;
                    ok_reg  <= (det_reg != '0);
                end
                INV_LOAD:
                begin
                    cnt_reg <= '0;
                end
                INV_DIV:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                INV_STORE:
                begin
                    ti_reg[ent_reg] <= ti_val;
                    ent_reg         <= ent_reg + 4'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            INV_ADJ_A:
            begin
                acc_reg <= ADJ_W'(adj_prod);
            end
            INV_ADJ_B:
            begin
                adj_mem[ent_reg] <= acc_reg - ADJ_W'(adj_prod);
            end
            INV_DET:
            begin
                det_reg <= (ent_reg == 4'd0) ? det_prod : det_reg + det_prod;
            end
            INV_CHECK:
            begin
                dmag_reg    <= det_reg[DET_W-1] ? (DET_W'(0) - det_reg) : det_reg;
                det_neg_reg <= det_reg[DET_W-1];
            end
            INV_LOAD:
            begin
                num_reg <= {(adj_rd[ADJ_W-1] ? (ADJ_W'(0) - adj_rd) : adj_rd), 31'd0};
                neg_reg <= adj_rd[ADJ_W-1] ^ det_neg_reg;
                rem_reg <= '0;
                q_reg   <= '0;
                sat_reg <= 1'b0;
            end
            INV_DIV:
            begin
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                rem_reg <= qbit ? rem_diff[DET_W-1:0] : rem_sh[DET_W-1:0];
                q_reg   <= {q_reg[31:0], qbit};
                sat_reg <= sat_reg | q_reg[32];
            end
            default:
            begin
            end
        endcase
    end

    assign inv_ok  = ok_reg;
    assign ti_bank = ti_reg;

endmodule

// ===== rtl/cpt_datapath.sv =====
module cpt_datapath
    import cpt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  in_t      req,
    input  ti_bank_t ti_bank,
    input  logic     inv_ok,
    output logic     out_valid,
    output out_t     result
);

    logic [4:0] vld_reg;

    logic signed [TI_W-1:0]   ti_s [3][3];
    logic signed [COEF_W:0]   a_mat [3][3];
    logic signed [64:0]       p1_reg [3][3][3];
    logic signed [66:0]       s2 [3][3];
    logic signed [49:0]       m_reg [3][3];
    logic signed [25:0]       mh [3][3];
    logic signed [24:0]       ml [3][3];
    logic signed [57:0]       ph_reg [6][3];
    logic signed [56:0]       pl_reg [6][3];
    logic signed [83:0]       s4 [6];
    logic signed [83:0]       s4_reg [6];
    logic signed [83:0]       rnd [6];
    logic signed [83:0]       shf [6];
    logic signed [COEF_W-1:0] sat_v [6];
    out_t res_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ti_s[r][c] = ti_bank[3*r + c];
                mh[r][c]   = m_reg[r][c][49:24];
                ml[r][c]   = $signed({1'b0, m_reg[r][c][23:0]});
            end
        end
        a_mat[0][0] = $signed({req.coef_const, 1'b0});
        a_mat[1][1] = $signed({req.coef_xx, 1'b0});
        a_mat[2][2] = $signed({req.coef_yy, 1'b0});
        a_mat[1][2] = {req.coef_xy[COEF_W-1], req.coef_xy};
        a_mat[2][1] = {req.coef_xy[COEF_W-1], req.coef_xy};
        a_mat[0][1] = {req.coef_x[COEF_W-1], req.coef_x};
        a_mat[1][0] = {req.coef_x[COEF_W-1], req.coef_x};
        a_mat[0][2] = {req.coef_y[COEF_W-1], req.coef_y};
        a_mat[2][0] = {req.coef_y[COEF_W-1], req.coef_y};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    p1_reg[i][j][k] <= a_mat[i][k] * ti_s[k][j];
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s2[i][j] = {{2{p1_reg[i][j][0][64]}}, p1_reg[i][j][0]}
                         + {{2{p1_reg[i][j][1][64]}}, p1_reg[i][j][1]}
                         + {{2{p1_reg[i][j][2][64]}}, p1_reg[i][j][2]}
                         + 67'sd65536;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m_reg[i][j] <= s2[i][j][66:17];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int o = 0; o < 6; o++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ph_reg[o][k] <= ti_s[k][out_row(o)] * mh[k][out_col(o)];
                pl_reg[o][k] <= ti_s[k][out_row(o)] * ml[k][out_col(o)];
            end
        end
    end

    always_comb
    begin
        for (int o = 0; o < 6; o++)
        begin
            s4[o] = '0;
            for (int k = 0; k < 3; k++)
            begin
                s4[o] = s4[o] + {{2{ph_reg[o][k][57]}}, ph_reg[o][k], 24'd0}
                              + {{27{pl_reg[o][k][56]}}, pl_reg[o][k]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int o = 0; o < 6; o++)
        begin
            s4_reg[o] <= s4[o];
        end
    end

    always_comb
    begin
        for (int o = 0; o < 6; o++)
        begin
            rnd[o] = s4_reg[o] + (84'sd1 <<< (out_shift(o) - 1));
            shf[o] = rnd[o] >>> out_shift(o);
            if ((~|shf[o][83:31]) || (&shf[o][83:31]))
            begin
                sat_v[o] = shf[o][31:0];
            end
            else
            begin
                sat_v[o] = shf[o][83] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
            if (!inv_ok)
            begin
                sat_v[o] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg.out_xx     <= sat_v[0];
        res_reg.out_yy     <= sat_v[1];
        res_reg.out_xy     <= sat_v[2];
        res_reg.out_x      <= sat_v[3];
        res_reg.out_y      <= sat_v[4];
        res_reg.out_const  <= sat_v[5];
        res_reg.invertible <= inv_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    assign out_valid = vld_reg[4];
    assign result    = res_reg;

endmodule

// ===== rtl/conic_projective_transform.sv =====
// Channel   | Handshake                   | Payload
// ----------+-----------------------------+---------------------------------
// request   | start, busy                 | req (coefficients of one conic)
// result    | result_valid (one cycle)    | result (coefficients, invertible)
// config    | cfg_valid, cfg_ready        | cfg_index, cfg_data (matrix row)
//
// A request is taken at every clock edge where start is high and busy is low, one per cycle.
// Its result is carried through the five register stages of the datapath.
// A configuration write starts a recompute of the inverse matrix with two multipliers and
// a bit-serial divider, during which busy is high and cfg_ready is low.
// Reset loads the identity matrix and its inverse, so no recompute follows reset.
// Results cannot be held off, so the datapath never stalls.
module conic_projective_transform
    import cpt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_t                  req,
    output logic                 result_valid,
    output out_t                 result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]     cfg_data
);

    rows_t    row_reg;
    logic     cfg_fire;
    logic     inv_busy;
    logic     inv_ok;
    ti_bank_t ti_bank;

    assign cfg_ready = !inv_busy;
    assign busy      = inv_busy;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= 63'h0000_0000_0000_4000;
            row_reg[1] <= 63'h0000_0008_0000_0000;
            row_reg[2] <= 63'h0100_0000_0000_0000;
        end
        else if (cfg_fire)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ROW0: row_reg[0] <= cfg_data;
                REG_ROW1: row_reg[1] <= cfg_data;
                REG_ROW2: row_reg[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    cpt_inverse u_inverse (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (cfg_fire),
        .rows    (row_reg),
        .busy    (inv_busy),
        .inv_ok  (inv_ok),
        .ti_bank (ti_bank)
    );

    cpt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .req       (req),
        .ti_bank   (ti_bank),
        .inv_ok    (inv_ok),
        .out_valid (result_valid),
        .result    (result)
    );

endmodule

// ===== rtl/cpt_checker.sv =====
module cpt_checker
    import cpt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input out_t result,
    input logic cfg_valid,
    input logic cfg_ready
);

    // Every accepted request yields exactly one result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##5 result_valid)
        else $error("request without result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 5))
        else $error("result without request");

    a_cfg_recompute: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> busy)
        else $error("configuration write did not start a recompute");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.invertible |->
            result.out_xx == 0 && result.out_yy == 0 && result.out_xy == 0 &&
            result.out_x == 0 && result.out_y == 0 && result.out_const == 0)
        else $error("singular matrix gave nonzero coefficients");

endmodule

bind conic_projective_transform cpt_checker u_checker (.*);

// ===== tb/tb_conic_projective_transform.sv =====
module tb_conic_projective_transform;
    import cpt_pkg::*;

    localparam int LATENCY_WAIT = 12;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam logic [ENTRY_W-1:0] ONE_Q14 = 21'd16384;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    in_t req = '0;
    logic result_valid;
    out_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_ROW0;
    logic [ROW_W-1:0] cfg_data = '0;

    rows_t matrix;
    in_t pending_conics[$];
    out_t expected_conics[$];
    bit request_taken = 0;
    bit cfg_taken = 0;
    int burst_left = 0;
    int gap_left = 0;
    int cycle_count = 0;
    int errors = 0;

    conic_projective_transform dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic signed [127:0] widen(input longint v);
        return 128'(v);
    endfunction

    function automatic longint round_shift(input logic signed [127:0] v, input int k);
        logic signed [127:0] s;
        s = v + (128'sd1 <<< (k - 1));
        if ((s >>> k) > 128'sh7FFFFFFFFFFFFFFF)
            return 64'sh7FFFFFFFFFFFFFFF;
        if ((s >>> k) < -128'sh8000000000000000)
            return 64'sh8000000000000000;
        return longint'(s >>> k);
    endfunction

    function automatic longint inverse_entry(input longint num, input longint den);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic [127:0] m;
        n = (num < 0) ? 128'(-num) : 128'(num);
        n = n & 128'hFFFFFFFFFFFFFFFF;
        d = (den < 0) ? 128'(-den) : 128'(den);
        d = d & 128'hFFFFFFFFFFFFFFFF;
        q = (n << 31) / d;
        m = (q >= (128'd1 << 33)) ? (128'd1 << 32) : ((q + 1) >> 1);
        if ((num < 0) != (den < 0))
        begin
            if (m > (128'd1 << 31))
                m = 128'd1 << 31;
            return -longint'(m);
        end
        if (m > (128'd1 << 31) - 1)
            m = (128'd1 << 31) - 1;
        return longint'(m);
    endfunction

    function automatic out_t transform_conic(input in_t c, input rows_t rows);
        longint t[3][3];
        longint adj[3][3];
        longint ti[3][3];
        longint a[3][3];
        longint m[3][3];
        longint det;
        longint v[7];
        logic signed [127:0] s;
        int p;
        int q;
        out_t r;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                t[i][j] = longint'(signed'(rows[i][ENTRY_W*j +: ENTRY_W]));
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                adj[i][j] = t[(j+1)%3][(i+1)%3] * t[(j+2)%3][(i+2)%3]
                          - t[(j+1)%3][(i+2)%3] * t[(j+2)%3][(i+1)%3];
        det = t[0][0] * adj[0][0] + t[0][1] * adj[1][0] + t[0][2] * adj[2][0];
        r = '0;
        if (det == 0)
            return r;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                ti[i][j] = inverse_entry(adj[i][j], det);
        a[1][1] = 2 * longint'(c.coef_xx);
        a[2][2] = 2 * longint'(c.coef_yy);
        a[1][2] = longint'(c.coef_xy);
        a[2][1] = longint'(c.coef_xy);
        a[0][1] = longint'(c.coef_x);
        a[1][0] = longint'(c.coef_x);
        a[0][2] = longint'(c.coef_y);
        a[2][0] = longint'(c.coef_y);
        a[0][0] = 2 * longint'(c.coef_const);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                s = widen(a[i][0]) * widen(ti[0][j]) + widen(a[i][1]) * widen(ti[1][j])
                  + widen(a[i][2]) * widen(ti[2][j]);
                m[i][j] = round_shift(s, 17);
            end
        for (int k = 0; k < 6; k++)
        begin
            p = out_row(k);
            q = out_col(k);
            s = widen(ti[0][p]) * widen(m[0][q]) + widen(ti[1][p]) * widen(m[1][q])
              + widen(ti[2][p]) * widen(m[2][q]);
            v[k] = round_shift(s, out_shift(k));
            if (v[k] > 64'sd2147483647)
                v[k] = 64'sd2147483647;
            if (v[k] < -64'sd2147483648)
                v[k] = -64'sd2147483648;
        end
        r.out_xx = v[0][31:0];
        r.out_yy = v[1][31:0];
        r.out_xy = v[2][31:0];
        r.out_x = v[3][31:0];
        r.out_y = v[4][31:0];
        r.out_const = v[5][31:0];
        r.invertible = 1'b1;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        out_t exp_r;
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            request_taken = start && !busy;
            if (request_taken)
                expected_conics.insert(expected_conics.size(), transform_conic(req, matrix));
            if (cfg_valid && cfg_ready)
            begin
                cfg_taken = 1;
                if (cfg_index != REG_NONE)
                    matrix[cfg_index] = cfg_data;
            end
            if (result_valid)
            begin
                if (expected_conics.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no request outstanding, actual %h", $time, result);
                end
                else
                begin
                    exp_r = expected_conics.pop_front();
                    check_field("out_xx", exp_r.out_xx, result.out_xx);
                    check_field("out_yy", exp_r.out_yy, result.out_yy);
                    check_field("out_xy", exp_r.out_xy, result.out_xy);
                    check_field("out_x", exp_r.out_x, result.out_x);
                    check_field("out_y", exp_r.out_y, result.out_y);
                    check_field("out_const", exp_r.out_const, result.out_const);
                    check_field("invertible", 32'(exp_r.invertible), 32'(result.invertible));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (request_taken)
        begin
            void'(pending_conics.pop_front());
            request_taken = 0;
        end
        if (burst_left == 0 && gap_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0 && burst_left == 0)
        begin
            gap_left--;
            start <= 1'b0;
        end
        else if (pending_conics.size() > 0 && rst_n)
        begin
            if (burst_left > 0)
                burst_left--;
            start <= 1'b1;
            req <= pending_conics[0];
        end
        else
            start <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_conic_projective_transform failed");
            $finish;
        end
    end

    function automatic logic [31:0] random_coef();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'h7FFFFFFF - $urandom_range(0, 2);
            2:       return 32'h80000000 + $urandom_range(0, 2);
            3:       return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
            default: return 32'($urandom_range(0, 32'h7FFFFF)) - 32'h400000;
        endcase
    endfunction

    function automatic logic [ENTRY_W-1:0] random_entry(input bit wide_range);
        if (wide_range)
            return ENTRY_W'($urandom);
        return ENTRY_W'($urandom_range(0, 32'h8000)) - ENTRY_W'(16384);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
        @(negedge clk);
        cfg_taken = 0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_matrix(input logic [ENTRY_W-1:0] e[9]);
        write_reg(REG_ROW0, {e[2], e[1], e[0]});
        write_reg(REG_ROW1, {e[5], e[4], e[3]});
        write_reg(REG_ROW2, {e[8], e[7], e[6]});
    endtask

    task automatic drain();
        while (pending_conics.size() > 0 || expected_conics.size() > 0)
            @(negedge clk);
        repeat (LATENCY_WAIT) @(negedge clk);
    endtask

    task automatic queue_random(input int count);
        in_t c;
        for (int n = 0; n < count; n++)
        begin
            c.coef_xx = random_coef();
            c.coef_yy = random_coef();
            c.coef_xy = random_coef();
            c.coef_x = random_coef();
            c.coef_y = random_coef();
            c.coef_const = random_coef();
            pending_conics.insert(pending_conics.size(), c);
        end
    endtask

    initial
    begin
        logic [ENTRY_W-1:0] e[9];
        in_t c;
        matrix[0] = ROW_W'(ONE_Q14);
        matrix[1] = ROW_W'(ONE_Q14) << ENTRY_W;
        matrix[2] = ROW_W'(ONE_Q14) << (2 * ENTRY_W);
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        c = '0;
        pending_conics.insert(pending_conics.size(), c);
        c = {6{32'h7FFFFFFF}};
        pending_conics.insert(pending_conics.size(), c);
        c = {6{32'h80000000}};
        pending_conics.insert(pending_conics.size(), c);
        c = {32'h00010000, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'hFFFF0000};
        pending_conics.insert(pending_conics.size(), c);
        c = {32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
        pending_conics.insert(pending_conics.size(), c);
        c = {6{32'hFFFFFFFF}};
        pending_conics.insert(pending_conics.size(), c);
        c = {6{32'h00000001}};
        pending_conics.insert(pending_conics.size(), c);
        queue_random(150);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            for (int k = 0; k < 9; k++)
                e[k] = random_entry(phase == 1 || phase == 6);
            case (phase)
                2: e = '{default: '0};
                3:
                begin
                    e = '{default: '0};
                    e[0] = 21'h0FFFFF;
                    e[4] = 21'h100000;
                    e[8] = 21'h0FFFFF;
                end
                4:
                begin
                    e = '{default: '0};
                    e[0] = 21'd1;
                    e[4] = 21'd1;
                    e[8] = 21'd1;
                end
                5:
                begin
                    e[3] = e[0] + 21'd1;
                    e[4] = e[1];
                    e[5] = e[2];
                end
                7:
                begin
                    e = '{default: 21'h1FFFFF};
                    e[0] = 21'h100000;
                    e[4] = 21'h100000;
                end
                default: ;
            endcase
            load_matrix(e);
            if (phase == 1)
                write_reg(REG_NONE, {3{21'h155555}});
            queue_random(phase == 2 ? 60 : 150);
            drain();
        end

        e = '{default: '0};
        e[0] = ONE_Q14;
        e[4] = ONE_Q14;
        e[8] = ONE_Q14;
        load_matrix(e);
        queue_random(40);
        drain();

        if (errors == 0)
            $display("tb_conic_projective_transform passed");
        else
            $display("tb_conic_projective_transform failed");
        $finish;
    end
endmodule

// ===== conic_projective_transform.f =====
rtl/cpt_pkg.sv
rtl/cpt_inverse.sv
rtl/cpt_datapath.sv
rtl/conic_projective_transform.sv
rtl/cpt_checker.sv
tb/tb_conic_projective_transform.sv
